// ----- rtl/flm_pkg.sv -----
// Shared types and constants of the floating literal matcher.
// Used by flm_core, float_literal_matcher and the testbench; depends on nothing else.
`default_nettype none

package flm_pkg;

  // Width of the length counters; the result field is fixed at 8 bits.
  localparam int unsigned LenBits = 8;
  localparam int unsigned MatchW  = 8;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  // Character codes that take part in the form.
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_req;
    logic       preceded_ok;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic              decided;
    logic [MatchW-1:0] match_len;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/flm_core.sv -----
// Recognizer state and per-character decision logic.
// Depends on flm_pkg; the state advances once per fired word.
`default_nettype none

module flm_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire flm_pkg::item_t  item_i,
  output flm_pkg::result_t     result_o
);

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhInt   = 3'd1,
    PhFrac  = 3'd2,
    PhEmark = 3'd3,
    PhEsign = 3'd4,
    PhEdig  = 3'd5
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [flm_pkg::LenBits-1:0] run_q, run_d;
  logic [flm_pkg::LenBits-1:0] mant_q, mant_d;

  phase_e                      ph;
  logic [flm_pkg::LenBits-1:0] run, mant, run_b, len;
  logic                        dig, done;

  always_comb begin
    ph      = phase_q;
    run     = run_q;
    mant    = mant_q;
    phase_d = phase_q;
    run_d   = run_q;
    mant_d  = mant_q;
    done    = 1'b0;
    len     = '0;
    dig     = flm_pkg::is_digit(item_i.char_code);

    if (item_i.start_req) begin
      ph   = PhInt;
      run  = '0;
      mant = '0;
    end
    run_b = (run == flm_pkg::LenMax) ? run : run + 1'b1;

    if (item_i.start_req && !item_i.preceded_ok) begin
      done = 1'b1;
    end else begin
      phase_d = ph;
      run_d   = run;
      mant_d  = mant;
      unique case (ph)
        PhInt: begin
          if (dig) begin
            run_d = run_b;
            done  = item_i.end_of_text;
          end else if (item_i.char_code == flm_pkg::ChPoint) begin
            run_d   = run_b;
            phase_d = PhFrac;
            done    = item_i.end_of_text;
            len     = (run_b == {{(flm_pkg::LenBits-1){1'b0}}, 1'b1}) ? '0 : run_b;
          end else begin
            done = 1'b1;
          end
        end
        PhFrac: begin
          if (dig) begin
            run_d = run_b;
            done  = item_i.end_of_text;
            len   = run_b;
          end else if (run == {{(flm_pkg::LenBits-1){1'b0}}, 1'b1}) begin
            // A point with no digits on either side is no literal.
            done = 1'b1;
          end else if (item_i.char_code == flm_pkg::ChLowE ||
                       item_i.char_code == flm_pkg::ChUpE) begin
            mant_d  = run;
            run_d   = run_b;
            phase_d = PhEmark;
            done    = item_i.end_of_text;
            len     = run;
          end else begin
            done = 1'b1;
            len  = run;
          end
        end
        PhEmark, PhEsign: begin
          if (ph == PhEmark && (item_i.char_code == flm_pkg::ChPlus ||
                                item_i.char_code == flm_pkg::ChMinus)) begin
            run_d   = run_b;
            phase_d = PhEsign;
            done    = item_i.end_of_text;
            len     = mant;
          end else if (dig) begin
            run_d   = run_b;
            phase_d = PhEdig;
            done    = item_i.end_of_text;
            len     = run_b;
          end else begin
            // An exponent without digits falls back to the mantissa.
            done = 1'b1;
            len  = mant;
          end
        end
        PhEdig: begin
          if (dig) begin
            run_d = run_b;
            done  = item_i.end_of_text;
            len   = run_b;
          end else begin
            done = 1'b1;
            len  = run;
          end
        end
        default: begin
          phase_d = PhIdle;
          run_d   = '0;
          mant_d  = '0;
        end
      endcase
    end

    if (done) begin
      phase_d = PhIdle;
      run_d   = '0;
      mant_d  = '0;
    end
    result_o.decided   = done;
    result_o.match_len = done ? flm_pkg::MatchW'(len) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      run_q   <= '0;
      mant_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      mant_q  <= mant_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_decide_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.decided |=> phase_q == PhIdle && run_q == '0)
    else $error("state not cleared after a decision");

  a_mant_le_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mant_q <= run_q)
    else $error("mantissa length exceeds run length");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> run_q == '0 && mant_q == '0)
    else $error("counters nonzero while idle");

  a_hold_unfired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(run_q))
    else $error("state moved without a word");
`endif

endmodule

`default_nettype wire

// ----- rtl/float_literal_matcher.sv -----
// Top level of the floating literal matcher: input and result registers
// around flm_core. Depends on flm_pkg and flm_core.
`default_nettype none

// The matcher takes one text character per word and answers every word with
// one result word carrying decided and match_len. It recognizes decimal
// literals of the form digits, point, digits, then an optional e or E, an
// optional sign and exponent digits; a lone point is rejected and an exponent
// without digits falls back to the mantissa length. A word with start_req set
// begins a new attempt (dropping any attempt in progress), and preceded_ok low
// on that word decides at once with length zero. match_len is zero whenever
// decided is low and saturates at 255. Throughput is one word per clock while
// the result side is not stalled: the recognizer state is a phase register and
// two length counters updated once per character. An accepted character is
// held in the input register, and its result word is registered in the result
// register when it fires; stalls on the result side hold it back. Both sides
// use valid/stall; in_stall_o rises only when both registers hold a word and
// the result side is stalled.

module float_literal_matcher (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire flm_pkg::item_t   in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      flm_pkg::result_t out_data_o
);

  logic             in_vld_q;
  flm_pkg::item_t   in_item_q;
  logic             out_vld_q;
  flm_pkg::result_t out_res_q;
  flm_pkg::result_t res;
  logic             fire;

  // The held character moves to the result register when that register is
  // empty or its word is being taken in this cycle.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;

  flm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_res_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_res_q))
    else $error("stalled result word was overwritten");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with room available");

  a_undecided_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_res_q.decided |-> out_res_q.match_len == '0)
    else $error("length reported without a decision");
`endif

endmodule

`default_nettype wire

// ----- test/float_literal_matcher_tb.sv -----
// Testbench for float_literal_matcher: directed and random character words checked
// against a predictor of the literal recognizer. Depends on flm_pkg and the RTL top.
`timescale 1ns / 1ps

module float_literal_matcher_tb;

  localparam int unsigned ItemsTarget = 1100;  // least number of words accepted over the whole run
  localparam int unsigned QuietFrom   = ItemsTarget - 150;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned PauseAt     = 650;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [2:0] {PhIdle, PhInt, PhFrac, PhMark, PhSign, PhExp} phase_e;

  // One line of the directed plan: the word and, where it is obvious, the
  // answer written out by hand.
  typedef struct {
    flm_pkg::item_t   w;
    bit               pinned;
    flm_pkg::result_t want;
  } plan_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  flm_pkg::item_t   in_data_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  flm_pkg::result_t out_data_o;

  float_literal_matcher DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: the attempt in progress.
  phase_e                      lit_phase = PhIdle;
  logic [flm_pkg::LenBits-1:0] lit_len   = '0;
  logic [flm_pkg::LenBits-1:0] mant_len  = '0;

  flm_pkg::result_t verdict_q[$];  // answers still owed by the block
  plan_row_t        plan_q[$];
  flm_pkg::item_t   burst_q[$];
  int unsigned      errors       = 0;
  int unsigned      fed_words    = 0;
  int unsigned      ticks        = 0;
  bit               quiet        = 1'b0;
  logic             in_fire_q    = 1'b0;
  bit               offer_pinned = 1'b0;
  flm_pkg::result_t offer_want   = '0;

  // Closes the attempt with the given length and returns to idle.
  function automatic flm_pkg::result_t settle(input logic [flm_pkg::LenBits-1:0] n);
    flm_pkg::result_t r;
    r.decided   = 1'b1;
    r.match_len = flm_pkg::MatchW'(n);
    lit_phase   = PhIdle;
    lit_len     = '0;
    mant_len    = '0;
    return r;
  endfunction

  // Advances the recognizer by one character and returns the answer word.
  function automatic flm_pkg::result_t match_step(input flm_pkg::item_t w);
    logic                        numeral;
    logic [flm_pkg::LenBits-1:0] grown;
    numeral = (w.char_code >= flm_pkg::ChZero) && (w.char_code <= flm_pkg::ChNine);
    if (w.start_req) begin
      if (!w.preceded_ok) return settle('0);
      lit_phase = PhInt;
      lit_len   = '0;
      mant_len  = '0;
    end
    // Length after taking this character, held at the top of the counter.
    grown = (lit_len == flm_pkg::LenMax) ? lit_len : lit_len + 1'b1;
    case (lit_phase)
      PhInt: begin
        if (numeral) begin
          lit_len = grown;
          if (w.end_of_text) return settle('0);
        end else if (w.char_code == flm_pkg::ChPoint) begin
          lit_len   = grown;
          lit_phase = PhFrac;
          // A point alone at the end of the text is no literal.
          if (w.end_of_text) return settle((lit_len == 1) ? '0 : lit_len);
        end else begin
          return settle('0);
        end
      end
      PhFrac: begin
        if (numeral) begin
          lit_len = grown;
          if (w.end_of_text) return settle(lit_len);
        end else if (lit_len == 1) begin
          return settle('0);
        end else begin
          mant_len = lit_len;
          if (w.char_code == flm_pkg::ChLowE || w.char_code == flm_pkg::ChUpE) begin
            lit_len   = grown;
            lit_phase = PhMark;
            if (w.end_of_text) return settle(mant_len);
          end else begin
            return settle(mant_len);
          end
        end
      end
      PhMark, PhSign: begin
        if (lit_phase == PhMark && (w.char_code == flm_pkg::ChPlus ||
                                    w.char_code == flm_pkg::ChMinus)) begin
          lit_len   = grown;
          lit_phase = PhSign;
          if (w.end_of_text) return settle(mant_len);
        end else if (numeral) begin
          lit_len   = grown;
          lit_phase = PhExp;
          if (w.end_of_text) return settle(lit_len);
        end else begin
          // Exponent mark without digits: the match ends with the mantissa.
          return settle(mant_len);
        end
      end
      PhExp: begin
        if (numeral) begin
          lit_len = grown;
          if (w.end_of_text) return settle(lit_len);
        end else begin
          return settle(lit_len);
        end
      end
      default: begin
        lit_phase = PhIdle;
        lit_len   = '0;
        mant_len  = '0;
      end
    endcase
    return '0;
  endfunction

  // Input side: every accepted word is fed to the predictor. Output side:
  // every accepted result word is compared with the oldest pending answer.
  always @(posedge clk_i) begin
    flm_pkg::result_t want;
    flm_pkg::result_t guess;
    in_fire_q <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result decided=%0b len=%0d arrived with nothing pending",
                 $time, out_data_o.decided, out_data_o.match_len);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.decided !== want.decided) begin
          $display("%0t: decided mismatch, expected %0b, got %0b",
                   $time, want.decided, out_data_o.decided);
          errors++;
        end
        if (out_data_o.match_len !== want.match_len) begin
          $display("%0t: match_len mismatch, expected %0d, got %0d",
                   $time, want.match_len, out_data_o.match_len);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fed_words++;
      guess = match_step(in_data_i);
      verdict_q = {verdict_q, (offer_pinned ? offer_want : guess)};
    end
  end

  // Watchdog.
  initial begin
    while (ticks < CycleLimit) begin
      @(posedge clk_i);
      ticks++;
    end
    $display("float_literal_matcher_tb: done, errors");
    $finish;
  end

  // Result side: random stall bursts, calm stretches, and one long hold-off
  // that lets both pipeline registers fill so the input gets stalled.
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    int unsigned calm_left;
    bit          held;
    hold_left  = 0;
    burst_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && fed_words >= HoldAt) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (quiet || !rst_ni) begin
        out_stall_i <= 1'b0;
      end else if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left != 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (calm_left != 0) begin
        out_stall_i <= 1'b0;
        calm_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(1, 17) - 1;
      end else begin
        out_stall_i <= 1'b0;
        calm_left = $urandom_range(1, 40);
      end
    end
  end

  task automatic plan(input logic [7:0] c, input logic s, input logic p, input logic e,
                      input bit pin, input logic d, input logic [flm_pkg::MatchW-1:0] n);
    plan_row_t row;
    row.w.char_code     = c;
    row.w.start_req     = s;
    row.w.preceded_ok   = p;
    row.w.end_of_text   = e;
    row.pinned          = pin;
    row.want.decided    = d;
    row.want.match_len  = n;
    plan_q = {plan_q, row};
  endtask

  // Offers one word and waits until the block has taken it. Outside the
  // last part a random gap may come first.
  task automatic offer(input flm_pkg::item_t w, input bit pin, input flm_pkg::result_t want);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    offer_pinned = pin;
    offer_want   = want;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(negedge clk_i); while (!in_fire_q);
  endtask

  task automatic push_char(input logic [7:0] c, input logic s, input logic p, input logic e);
    flm_pkg::item_t w;
    w.char_code   = c;
    w.start_req   = s;
    w.preceded_ok = p;
    w.end_of_text = e;
    burst_q = {burst_q, w};
  endtask

  function automatic logic [7:0] any_digit();
    return flm_pkg::ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic int unsigned digit_count();
    // Now and then a run long enough to saturate the length counter.
    return ($urandom_range(0, 89) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 4);
  endfunction

  // Builds one random sequence: mostly a well-formed literal with random
  // digits, some literals with one character damaged, some plain noise.
  task automatic gen_burst();
    int unsigned    kind;
    int unsigned    cut;
    logic           prec;
    flm_pkg::item_t w;
    burst_q.delete();
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 6))
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      return;
    end
    prec = ($urandom_range(0, 15) != 0);
    repeat (digit_count()) push_char(any_digit(), 1'b0, 1'b0, 1'b0);
    push_char(flm_pkg::ChPoint, 1'b0, 1'b0, 1'b0);
    repeat (digit_count()) push_char(any_digit(), 1'b0, 1'b0, 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      push_char($urandom_range(0, 1) ? flm_pkg::ChLowE : flm_pkg::ChUpE, 1'b0, 1'b0, 1'b0);
      if ($urandom_range(0, 2) == 0)
        push_char($urandom_range(0, 1) ? flm_pkg::ChPlus : flm_pkg::ChMinus,
                  1'b0, 1'b0, 1'b0);
      repeat ($urandom_range(0, 3)) push_char(any_digit(), 1'b0, 1'b0, 1'b0);
    end
    w = burst_q[0];
    w.start_req   = 1'b1;
    w.preceded_ok = prec;
    burst_q[0]    = w;
    case ($urandom_range(0, 3))
      0: begin
        w = burst_q.pop_back();
        w.end_of_text = 1'b1;
        burst_q = {burst_q, w};
      end
      1: push_char(8'h20, 1'b0, 1'b0, 1'b0);  // space
      2: push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      default: ;
    endcase
    if (kind >= 6) begin
      cut = $urandom_range(0, burst_q.size() - 1);
      w   = burst_q[cut];
      case ($urandom_range(0, 2))
        0: w.char_code = 8'($urandom_range(0, 255));
        1: begin
          w.start_req   = 1'b1;
          w.preceded_ok = 1'($urandom_range(0, 1));
        end
        default: w.end_of_text = 1'b1;
      endcase
      burst_q[cut] = w;
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;

    // Directed plan. Answers are written out for the idle and refused
    // cases; everything else goes through the predictor.
    plan(8'h78, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0);  // 'x' right after reset
    plan(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0);  // start not after a delimiter
    plan(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0);  // idle again
    plan(8'h31, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);  // "1.5e-9 "
    plan(flm_pkg::ChPoint, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(8'h35, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChLowE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChMinus, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChNine, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChPoint, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);  // a lone point
    plan(8'h3B, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(8'h37, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0);  // digits end the text
    // "0.E+," has no exponent digits.
    plan(flm_pkg::ChZero, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChPoint, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChUpE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChPlus, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(8'h2C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(8'h34, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);  // restarted before settling
    plan(8'h32, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChPoint, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0);
    plan(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);  // non-digit opens an attempt
    // "9.e" at end of text.
    plan(flm_pkg::ChNine, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChPoint, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    plan(flm_pkg::ChLowE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[i]) offer(plan_q[i].w, plan_q[i].pinned, plan_q[i].want);

    while (fed_words < ItemsTarget) begin
      gen_burst();
      foreach (burst_q[i]) offer(burst_q[i], 1'b0, '0);
      if (!paused && fed_words >= PauseAt) begin
        // Let the block empty out completely before going on.
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (verdict_q.size() != 0);
      end
      if (fed_words >= QuietFrom) quiet = 1'b1;
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (verdict_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("float_literal_matcher_tb: done, clean");
    end else begin
      $display("float_literal_matcher_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/flm_pkg.sv
rtl/flm_core.sv
rtl/float_literal_matcher.sv
test/float_literal_matcher_tb.sv
